>>> rtl/asrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrm_pkg: shared types and constants
// Command and status codes, sequencer states and sizes of the symbol model.
// ----------------------------------------------------------------------------
package asrm_pkg;

  localparam int Symbols   = 256;
  localparam int SlotBits  = 8;
  localparam int CountBits = 32;
  localparam logic [CountBits-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_RESET  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_SAT    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_WRITE,
    S_SCAN,
    S_DIV,
    S_MUL_LO,
    S_MUL_HI,
    S_OUT
  } state_t;

  // Start/busy handshake with the shared arithmetic unit
  typedef struct packed {
    logic        start_div;
    logic        start_mul;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
  } arith_req_t;

  typedef struct packed {
    logic        busy;
    logic [63:0] result;
  } arith_rsp_t;

endpackage

>>> rtl/asrm_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asrm_arith: shared shift/subtract unit
// Restoring division of all ones by the total, and a shift-add multiply,
// one bit per cycle on 64-bit operands.
// ----------------------------------------------------------------------------
module asrm_arith (
  input  logic                  clk,
  input  logic                  rst,
  input  asrm_pkg::arith_req_t  req,
  input  logic [31:0]           divisor,
  output asrm_pkg::arith_rsp_t  rsp
);

  logic        busy;
  logic        is_div;
  logic [6:0]  cnt;
  logic [63:0] rem;
  logic [63:0] acc;
  logic [63:0] opa;
  logic [63:0] opb;
  logic [64:0] trial;

  assign trial = {rem, 1'b1} - {33'd0, divisor};

  // Iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start_div) begin
      busy   <= 1'b1;
      is_div <= 1'b1;
      cnt    <= 7'd64;
      rem    <= '0;
      acc    <= '0;
    end else if (req.start_mul) begin
      busy   <= 1'b1;
      is_div <= 1'b0;
      cnt    <= 7'd64;
      acc    <= '0;
      opa    <= req.mul_a;
      opb    <= req.mul_b;
    end else if (busy) begin
      if (is_div) begin
        // dividend bits are all ones
        if (!trial[64] || rem[63]) begin
          rem <= trial[63:0];
          acc <= {acc[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], 1'b1};
          acc <= {acc[62:0], 1'b0};
        end
      end else begin
        if (opb[0]) acc <= acc + opa;
        opa <= {opa[62:0], 1'b0};
        opb <= {1'b0, opb[63:1]};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  assign rsp.busy   = busy;
  assign rsp.result = acc;

endmodule

>>> rtl/adaptive_symbol_range_model_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_symbol_range_model_unit: adaptive frequency table for a range coder
// Keeps per-symbol counts and answers range queries on the 64-bit code space.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry a command and a signed symbol; each beat yields
// exactly one output beat on m_axis with status, range and running total.
// One item is processed at a time; s_axis_tready is low while it is in work.
// Reset counts walks all 256 slots. A query walks the 256 counts for the prefix
// (one memory read per cycle), then runs the division of all ones by the total
// and two multiplies on the shared shift/add unit.
// The result sits in an output register; a stalled receiver holds it and
// s_axis_tready stays low until the beat is taken.
// Reset clears the present bits and the total; counts are written before use.
// ----------------------------------------------------------------------------
module adaptive_symbol_range_model_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [1:0] command, [9:2] symbol
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata    // [1:0] status, [65:2] range_low,
                                       // [129:66] range_high, [161:130] total_count
);

  asrm_pkg::state_t state, state_next;

  logic [asrm_pkg::Symbols-1:0] present;
  logic [31:0] counts [asrm_pkg::Symbols];
  logic [31:0] rd_data;
  logic [7:0]  rd_addr;
  logic        wr_en;
  logic [7:0]  wr_addr;
  logic [31:0] wr_data;

  logic [1:0]  cmd;
  logic [7:0]  slot;
  logic [8:0]  idx;
  logic [63:0] prefix;
  logic [31:0] own;
  logic        highest;
  logic [63:0] slot_size;
  logic [63:0] range_low;
  logic [1:0]  status;
  logic [63:0] lo_r, hi_r;
  logic [31:0] total;
  logic [8:0]  npres;

  asrm_pkg::arith_req_t req;
  asrm_pkg::arith_rsp_t rsp;

  asrm_arith u_arith (.clk(clk), .rst(rst), .req(req), .divisor(total), .rsp(rsp));

  // Count memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) counts[wr_addr] <= wr_data;
    rd_data <= counts[rd_addr];
  end

  assign s_axis_tready = (state == asrm_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= asrm_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    req = '0;
    req.mul_a = slot_size;
    req.mul_b = prefix;
    unique case (state)
      asrm_pkg::S_IDLE:  if (s_axis_tvalid) state_next = asrm_pkg::S_LOOK;
      asrm_pkg::S_LOOK: begin
        if (cmd == asrm_pkg::CMD_RESET) state_next = asrm_pkg::S_SCAN;
        else if (cmd == asrm_pkg::CMD_QUERY) begin
          if (!present[slot] || total == '0) state_next = asrm_pkg::S_OUT;
          else state_next = asrm_pkg::S_SCAN;
        end else state_next = asrm_pkg::S_WRITE;
      end
      asrm_pkg::S_WRITE: state_next = asrm_pkg::S_OUT;
      asrm_pkg::S_SCAN: if (idx == 9'd257) begin
        if (cmd == asrm_pkg::CMD_QUERY) begin
          state_next = asrm_pkg::S_DIV;
          req.start_div = 1'b1;
        end else state_next = asrm_pkg::S_OUT;
      end
      asrm_pkg::S_DIV: if (!rsp.busy && !req.start_div) begin
        state_next = asrm_pkg::S_MUL_LO;
        req.start_mul = 1'b1;
        req.mul_a = rsp.result;
      end
      asrm_pkg::S_MUL_LO: if (!rsp.busy) begin
        state_next = asrm_pkg::S_MUL_HI;
        req.start_mul = 1'b1;
        req.mul_b = {32'd0, own};
      end
      asrm_pkg::S_MUL_HI: if (!rsp.busy) state_next = asrm_pkg::S_OUT;
      asrm_pkg::S_OUT: if (m_axis_tready) state_next = asrm_pkg::S_IDLE;
      default: state_next = asrm_pkg::S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    rd_addr = idx[7:0];
    wr_en   = 1'b0;
    wr_addr = slot;
    wr_data = 32'd1;
    if (state == asrm_pkg::S_WRITE && status == asrm_pkg::ST_DONE) begin
      wr_en = 1'b1;
      if (cmd == asrm_pkg::CMD_UPDATE) wr_data = rd_data + 32'd1;
    end
    if (state == asrm_pkg::S_SCAN && cmd == asrm_pkg::CMD_RESET && !idx[8]) begin
      wr_en   = present[idx[7:0]];
      wr_addr = idx[7:0];
    end
    if (state == asrm_pkg::S_LOOK) rd_addr = slot;
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      total   <= '0;
    end else begin
      unique case (state)
        asrm_pkg::S_IDLE: if (s_axis_tvalid) begin
          cmd    <= s_axis_tdata[1:0];
          slot   <= s_axis_tdata[9:2] ^ 8'h80;
          lo_r   <= '0;
          hi_r   <= '0;
          status <= asrm_pkg::ST_DONE;
          idx    <= '0;
          prefix <= '0;
          npres  <= '0;
          highest <= 1'b1;
        end
        asrm_pkg::S_LOOK: begin
          if (cmd == asrm_pkg::CMD_ADD) begin
            if (present[slot]) status <= asrm_pkg::ST_ABSENT;
            else if (total == asrm_pkg::CountMax) status <= asrm_pkg::ST_SAT;
          end else if (cmd == asrm_pkg::CMD_UPDATE) begin
            if (!present[slot]) status <= asrm_pkg::ST_ABSENT;
            else if (total == asrm_pkg::CountMax) status <= asrm_pkg::ST_SAT;
          end else if (cmd == asrm_pkg::CMD_QUERY) begin
            if (!present[slot] || total == '0) status <= asrm_pkg::ST_ABSENT;
          end
        end
        asrm_pkg::S_WRITE: if (status == asrm_pkg::ST_DONE) begin
          total <= total + 32'd1;
          if (cmd == asrm_pkg::CMD_ADD) present[slot] <= 1'b1;
        end
        asrm_pkg::S_SCAN: begin
          idx <= idx + 9'd1;
          // read data is registered, so it belongs to the previous index
          if (idx != 9'd0 && idx <= 9'd256) begin
            if (present[idx[7:0] - 8'd1]) begin
              if ({1'b0, idx[7:0] - 8'd1} < {1'b0, slot} && idx[7:0] - 8'd1 < slot)
                prefix <= prefix + {32'd0, rd_data};
              if (idx[7:0] - 8'd1 == slot) own <= rd_data;
              if (idx[7:0] - 8'd1 > slot) highest <= 1'b0;
              npres <= npres + 9'd1;
            end
          end
          if (idx == 9'd257 && cmd == asrm_pkg::CMD_RESET) total <= {23'd0, npres};
        end
        asrm_pkg::S_DIV: if (!rsp.busy) slot_size <= rsp.result;
        asrm_pkg::S_MUL_LO: if (!rsp.busy && state_next == asrm_pkg::S_MUL_HI) begin
          range_low <= rsp.result;
          lo_r      <= rsp.result;
        end
        asrm_pkg::S_MUL_HI: if (!rsp.busy) begin
          hi_r <= highest ? '1 : range_low + rsp.result;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = (state == asrm_pkg::S_OUT);
  assign m_axis_tdata  = {6'd0, total, hi_r, lo_r, status};

endmodule

>>> verif/tb_adaptive_symbol_range_model_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_symbol_range_model_unit: self-checking bench for the symbol model
// Drives command beats (add, update, query, reset counts) from a directed table
// and then at random, predicts every response beat from its own frequency table
// and compares status, range bounds and total field by field.
// ----------------------------------------------------------------------------
module tb_adaptive_symbol_range_model_unit;

  localparam int NumRandom = 900;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [31:0] total;
  } resp_t;

  typedef struct {
    asrm_pkg::cmd_t cmd;
    logic [7:0]     sym;
    logic           known;
    resp_t          resp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;

  adaptive_symbol_range_model_unit DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: presence bits, counts indexed by slot, running total
  logic        sym_present [asrm_pkg::Symbols];
  logic [31:0] sym_count [asrm_pkg::Symbols];
  logic [31:0] sum_count;
  resp_t       pending_resp [$];
  int errors = 0;
  int beats_out = 0;
  int queries_hit = 0;
  bit stim_done = 0;
  bit hold_long = 0;

  function automatic resp_t predict_range(asrm_pkg::cmd_t cmd, logic [7:0] sym);
    resp_t r;
    int s;
    logic [63:0] slot_size, prefix;
    bit top;
    int n;
    r = '0;
    s = int'(sym ^ 8'h80);
    case (cmd)
      asrm_pkg::CMD_ADD: begin
        if (sym_present[s]) r.status = asrm_pkg::ST_ABSENT;
        else if (sum_count == asrm_pkg::CountMax) r.status = asrm_pkg::ST_SAT;
        else begin
          sym_present[s] = 1'b1;
          sym_count[s] = 32'd1;
          sum_count++;
        end
      end
      asrm_pkg::CMD_UPDATE: begin
        if (!sym_present[s]) r.status = asrm_pkg::ST_ABSENT;
        else if (sum_count == asrm_pkg::CountMax) r.status = asrm_pkg::ST_SAT;
        else begin
          sym_count[s]++;
          sum_count++;
        end
      end
      asrm_pkg::CMD_QUERY: begin
        if (!sym_present[s] || sum_count == 0) r.status = asrm_pkg::ST_ABSENT;
        else begin
          slot_size = 64'hFFFF_FFFF_FFFF_FFFF / {32'd0, sum_count};
          prefix = '0;
          top = 1;
          for (int i = 0; i < asrm_pkg::Symbols; i++) begin
            if (sym_present[i] && i < s) prefix += {32'd0, sym_count[i]};
            if (sym_present[i] && i > s) top = 0;
          end
          r.lo = prefix * slot_size;
          r.hi = r.lo + {32'd0, sym_count[s]} * slot_size;
          if (top) r.hi = '1;
          queries_hit++;
        end
      end
      default: begin
        n = 0;
        for (int i = 0; i < asrm_pkg::Symbols; i++) begin
          if (sym_present[i]) begin
            sym_count[i] = 32'd1;
            n++;
          end
        end
        sum_count = 32'(n);
      end
    endcase
    r.total = sum_count;
    return r;
  endfunction

  // Directed table; rows with known=1 carry a response read off by hand
  row_t dir_rows [$];

  task automatic add_row(asrm_pkg::cmd_t c, logic [7:0] s, logic k = 0, resp_t r = '0);
    row_t w;
    w.cmd = c; w.sym = s; w.known = k; w.resp = r;
    dir_rows.push_back(w);
  endtask

  task automatic send_beat(asrm_pkg::cmd_t c, logic [7:0] s);
    int gap;
    gap = hold_long ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      @(posedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(posedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, s, c};
    do @(posedge clk); while (!s_axis_tready);
    pending_resp.push_back(predict_range(c, s));
    s_axis_tvalid <= 1'b0;
  endtask

  // Sender: directed table, then random traffic skewed toward a small alphabet
  initial begin
    asrm_pkg::cmd_t c;
    logic [7:0] s;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < asrm_pkg::Symbols; i++) begin
      sym_present[i] = 0;
      sym_count[i] = 0;
    end
    sum_count = 0;
    add_row(asrm_pkg::CMD_QUERY, 8'h00, 1, '{asrm_pkg::ST_ABSENT, 0, 0, 0});
    add_row(asrm_pkg::CMD_UPDATE, 8'h80, 1, '{asrm_pkg::ST_ABSENT, 0, 0, 0});
    add_row(asrm_pkg::CMD_RESET, 8'h7F, 1, '{asrm_pkg::ST_DONE, 0, 0, 0});
    add_row(asrm_pkg::CMD_ADD, 8'h80, 1, '{asrm_pkg::ST_DONE, 0, 0, 1});
    add_row(asrm_pkg::CMD_QUERY, 8'h80, 1, '{asrm_pkg::ST_DONE, 0, '1, 1});
    add_row(asrm_pkg::CMD_ADD, 8'h80, 1, '{asrm_pkg::ST_ABSENT, 0, 0, 1});
    add_row(asrm_pkg::CMD_ADD, 8'h7F, 1, '{asrm_pkg::ST_DONE, 0, 0, 2});
    add_row(asrm_pkg::CMD_UPDATE, 8'h7F);
    add_row(asrm_pkg::CMD_UPDATE, 8'h7F);
    add_row(asrm_pkg::CMD_QUERY, 8'h80);
    add_row(asrm_pkg::CMD_QUERY, 8'h7F);
    add_row(asrm_pkg::CMD_ADD, 8'h00);
    add_row(asrm_pkg::CMD_ADD, 8'hFF);
    add_row(asrm_pkg::CMD_UPDATE, 8'h00);
    add_row(asrm_pkg::CMD_QUERY, 8'hFF);
    add_row(asrm_pkg::CMD_QUERY, 8'h00);
    add_row(asrm_pkg::CMD_QUERY, 8'h55);
    add_row(asrm_pkg::CMD_RESET, 8'hAA);
    add_row(asrm_pkg::CMD_QUERY, 8'h7F);
    add_row(asrm_pkg::CMD_UPDATE, 8'h80);
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].known) begin
        automatic resp_t p;
        send_beat(dir_rows[i].cmd, dir_rows[i].sym);
        p = pending_resp[$];
        if (p != dir_rows[i].resp) begin
          errors++;
          if (errors <= 10)
            $display("table row %0d: expected %h predicted %h", i,
                     dir_rows[i].resp, p);
        end
      end else begin
        send_beat(dir_rows[i].cmd, dir_rows[i].sym);
      end
    end
    for (int n = 0; n < NumRandom; n++) begin
      if ($urandom_range(0, 9) < 8) s = 8'($urandom_range(0, 15)) ^ 8'h78;
      else s = 8'($urandom);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: c = asrm_pkg::CMD_ADD;
        5, 6, 7, 8, 9, 10, 11: c = asrm_pkg::CMD_UPDATE;
        19: c = asrm_pkg::CMD_RESET;
        default: c = asrm_pkg::CMD_QUERY;
      endcase
      if (n == 300) hold_long = 1;
      send_beat(c, s);
      hold_long = 0;
    end
    stim_done = 1;
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps offering
  initial begin
    resp_t got, want;
    int stall;
    @(negedge rst);
    forever begin
      if (hold_long) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      stall = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) stall = 0;
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got = '{m_axis_tdata[1:0], m_axis_tdata[65:2], m_axis_tdata[129:66],
              m_axis_tdata[161:130]};
      beats_out++;
      if (pending_resp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response beat %h", m_axis_tdata);
      end else begin
        want = pending_resp.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("beat %0d: status %0d/%0d lo %h/%h hi %h/%h total %0d/%0d",
                     beats_out, want.status, got.status, want.lo, got.lo,
                     want.hi, got.hi, want.total, got.total);
        end
      end
    end
  end

  // Watchdog on idle cycles, and end of run
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle = 0;
      else idle++;
      if (idle >= WatchLimit) begin
        $display("timeout with %0d responses outstanding", pending_resp.size());
        $display("status: fail");
        $finish;
      end
      if (stim_done && pending_resp.size() == 0) begin
        repeat (600) @(posedge clk);
        if (m_axis_tvalid) errors++;
        $display("covered %0d commands, %0d responses, %0d in-range queries",
                 dir_rows.size() + NumRandom, beats_out, queries_hit);
        if (errors == 0) begin
          $display("status: pass");
        end else begin
          $display("mismatches: %0d", errors);
          $display("status: fail");
        end
        $finish;
      end
    end
  end

endmodule
